[rtl/ifrc_pkg.sv]
// Package: shared types and codes for the image fit rectangle calculator.
package ifrc_pkg;

    localparam logic [1:0] MODE_FILL    = 2'd0;
    localparam logic [1:0] MODE_CONTAIN = 2'd1;
    localparam logic [1:0] MODE_COVER   = 2'd2;
    localparam logic [1:0] MODE_SCALE   = 2'd3;

    localparam logic [2:0] REG_FIT_MODE = 3'd0;
    localparam logic [2:0] REG_BOUNDS_X = 3'd1;
    localparam logic [2:0] REG_BOUNDS_Y = 3'd2;
    localparam logic [2:0] REG_BOUNDS_W = 3'd3;
    localparam logic [2:0] REG_BOUNDS_H = 3'd4;

    // Operation codes handed from front to back.
    localparam logic [1:0] OP_PASS = 2'd0;  // full source, full bounds
    localparam logic [1:0] OP_CENT = 2'd1;  // unscaled centering
    localparam logic [1:0] OP_DSTD = 2'd2;  // contain: scale dst dimension
    localparam logic [1:0] OP_SRCD = 2'd3;  // cover: crop src dimension

    typedef struct packed {
        logic [12:0] tex_width;
        logic [12:0] tex_height;
    } t_in;

    typedef struct packed {
        logic [16:0] src_x;
        logic [16:0] src_y;
        logic [16:0] src_w;
        logic [16:0] src_h;
        logic [20:0] dst_x;
        logic [20:0] dst_y;
        logic [16:0] dst_w;
        logic [16:0] dst_h;
        logic        zero_size_error;
    } t_out;

endpackage

[rtl/ifrc_front.sv]
// Front end: saturates dimensions, compares aspect, classifies the operation.
module ifrc_front import ifrc_pkg::*; #(
    parameter int MAX_DIM_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    input  logic [1:0]            i_fit_mode,
    input  logic [12:0]           i_bounds_w,
    input  logic [12:0]           i_bounds_h,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_op,
    output logic                  o_wider,
    output logic                  o_err,
    output logic [MAX_DIM_BITS:0] o_tw,
    output logic [MAX_DIM_BITS:0] o_th,
    output logic [MAX_DIM_BITS:0] o_bw,
    output logic [MAX_DIM_BITS:0] o_bh
);
    localparam int DW = MAX_DIM_BITS + 1;
    localparam logic [DW-1:0] DMAX = DW'(1) << MAX_DIM_BITS;

    logic r_vld;
    logic [1:0] r_op;
    logic r_wider, r_err;
    logic [DW-1:0] r_tw, r_th, r_bw, r_bh;
    logic [DW-1:0] tw, th, bw, bh;
    logic [2*DW-1:0] p1, p2;
    logic err, wider, fits;
    logic [1:0] op;

    // Compare at full width so no input bit is lost before the check.
    function automatic logic [DW-1:0] sat(input logic [12:0] v);
        sat = (32'(v) > 32'(DMAX)) ? DMAX : DW'(v);
    endfunction

    always_comb begin
        tw = sat(i_data.tex_width);
        th = sat(i_data.tex_height);
        bw = sat(i_bounds_w);
        bh = sat(i_bounds_h);
        p1 = tw * bh;
        p2 = th * bw;
        wider = p1 > p2;
        err = (tw == '0) || (th == '0) || (bw == '0) || (bh == '0);
        fits = (tw <= bw) && (th <= bh);
        case (i_fit_mode)
            MODE_FILL:    op = OP_PASS;
            MODE_CONTAIN: op = OP_DSTD;
            MODE_COVER:   op = OP_SRCD;
            MODE_SCALE:   op = fits ? OP_CENT : OP_DSTD;
            default:      op = OP_PASS;
        endcase
        if (err) op = OP_PASS;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_op <= op; r_wider <= wider; r_err <= err;
            r_tw <= tw; r_th <= th; r_bw <= bw; r_bh <= bh;
        end
    end

    assign o_valid = r_vld;
    assign o_op = r_op;
    assign o_wider = r_wider;
    assign o_err = r_err;
    assign o_tw = r_tw;
    assign o_th = r_th;
    assign o_bw = r_bw;
    assign o_bh = r_bh;
endmodule

[rtl/ifrc_queue.sv]
// Two-entry queue between front and back.
module ifrc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

[rtl/ifrc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module ifrc_div #(
    parameter int NW = 30,
    parameter int DW = 13,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic          r_vld [1:NW];
    logic [NW-1:0] r_q   [1:NW];
    logic [DW-1:0] r_rem [1:NW];
    logic [DW-1:0] r_den [1:NW];
    logic [TW-1:0] r_tag [1:NW];

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic          vld_in;
        logic [NW-1:0] q_in;
        logic [DW-1:0] rem_in, den_in;
        logic [TW-1:0] tag_in;
        logic [DW:0]   t;
        logic          ge;

        // First stage takes the ports, the rest take the stage before.
        if (s == 0) begin : g_in
            assign vld_in = i_valid;
            assign q_in   = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
            assign tag_in = i_tag;
        end else begin : g_mid
            assign vld_in = r_vld[s];
            assign q_in   = r_q[s];
            assign rem_in = r_rem[s];
            assign den_in = r_den[s];
            assign tag_in = r_tag[s];
        end

        assign t = {rem_in, q_in[NW-1]};
        assign ge = t >= {1'b0, den_in};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= vld_in;
            end
            if (i_en) begin
                r_rem[s+1] <= ge ? DW'(t - {1'b0, den_in}) : DW'(t);
                r_q[s+1]   <= {q_in[NW-2:0], ge};
                r_den[s+1] <= den_in;
                r_tag[s+1] <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo = r_q[NW];
    assign o_tag = r_tag[NW];
endmodule

[rtl/ifrc_back.sv]
// Back end: multiply, divide pipeline, final offsets and output register.
module ifrc_back import ifrc_pkg::*; #(
    parameter int MAX_DIM_BITS = 12,
    parameter int FRAC_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic                  i_wider,
    input  logic                  i_err,
    input  logic [MAX_DIM_BITS:0] i_tw,
    input  logic [MAX_DIM_BITS:0] i_th,
    input  logic [MAX_DIM_BITS:0] i_bw,
    input  logic [MAX_DIM_BITS:0] i_bh,
    input  logic [15:0]           i_bounds_x,
    input  logic [15:0]           i_bounds_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out                  o_data
);
    localparam int DW = MAX_DIM_BITS + 1;
    localparam int NW = 2 * DW + FRAC_BITS;
    localparam int TW = 2 + 1 + 1 + 4 * DW;
    // Fixed-point working width: a full dimension, never below the offset width.
    localparam int XW = (DW + FRAC_BITS > 21) ? DW + FRAC_BITS : 21;
    typedef struct packed {
        logic [1:0]    op;
        logic          wider;
        logic          err;
        logic [DW-1:0] tw, th, bw, bh;
    } t_tag;

    logic en;
    // Output register empty or being drained: whole pipe advances.
    logic r_ovld;
    assign en = !r_ovld || i_ready;
    assign o_ready = en;

    // Stage 1: register the product and divisor.
    logic          r1_vld;
    logic [NW-1:0] r1_num;
    logic [DW-1:0] r1_den;
    t_tag          r1_tag;
    logic [DW-1:0] ma, mb, den;

    always_comb begin
        // contain wider: bw*th/tw; contain tall: bh*tw/th
        // cover wider: th*bw/bh;   cover tall: tw*bh/bw
        if (i_op == OP_DSTD) begin
            ma = i_wider ? i_bw : i_bh;
            mb = i_wider ? i_th : i_tw;
            den = i_wider ? i_tw : i_th;
        end else begin
            ma = i_wider ? i_th : i_tw;
            mb = i_wider ? i_bw : i_bh;
            den = i_wider ? i_bh : i_bw;
        end
        if (den == '0) den = DW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
        if (en) begin
            r1_num <= (NW'(ma) * NW'(mb)) << FRAC_BITS;
            r1_den <= den;
            r1_tag <= '{i_op, i_wider, i_err, i_tw, i_th, i_bw, i_bh};
        end
    end

    logic          d_vld;
    logic [NW-1:0] d_q;
    logic [TW-1:0] d_tag_raw;
    t_tag          d_tag;

    ifrc_div #(.NW(NW), .DW(DW), .TW(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r1_vld), .i_num(r1_num), .i_den(r1_den), .i_tag(r1_tag),
        .o_valid(d_vld), .o_quo(d_q), .o_tag(d_tag_raw)
    );
    assign d_tag = t_tag'(d_tag_raw);

    t_out res;
    logic signed [20:0] bx, by;
    logic [XW-1:0] tw_f, th_f, bw_f, bh_f, q;

    always_comb begin
        bx = 21'(signed'(i_bounds_x)) <<< FRAC_BITS;
        by = 21'(signed'(i_bounds_y)) <<< FRAC_BITS;
        tw_f = XW'(d_tag.tw) << FRAC_BITS;
        th_f = XW'(d_tag.th) << FRAC_BITS;
        bw_f = XW'(d_tag.bw) << FRAC_BITS;
        bh_f = XW'(d_tag.bh) << FRAC_BITS;
        q = XW'(d_q);
        res.src_x = '0;
        res.src_y = '0;
        res.src_w = 17'(tw_f);
        res.src_h = 17'(th_f);
        res.dst_x = bx;
        res.dst_y = by;
        res.dst_w = 17'(bw_f);
        res.dst_h = 17'(bh_f);
        res.zero_size_error = d_tag.err;
        case (d_tag.op)
            OP_PASS: ;
            OP_CENT: begin
                res.dst_x = bx + 21'((bw_f - tw_f) >> 1);
                res.dst_y = by + 21'((bh_f - th_f) >> 1);
                res.dst_w = 17'(tw_f);
                res.dst_h = 17'(th_f);
            end
            OP_DSTD: begin
                if (d_tag.wider) begin
                    res.dst_y = by + 21'((bh_f - q) >> 1);
                    res.dst_h = 17'(q);
                end else begin
                    res.dst_x = bx + 21'((bw_f - q) >> 1);
                    res.dst_w = 17'(q);
                end
            end
            OP_SRCD: begin
                if (d_tag.wider) begin
                    res.src_x = 17'((tw_f - q) >> 1);
                    res.src_w = 17'(q);
                end else begin
                    res.src_y = 17'((th_f - q) >> 1);
                    res.src_h = 17'(q);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= d_vld;
        end
        if (en && d_vld) o_data <= res;
    end
    assign o_valid = r_ovld;
endmodule

[rtl/image_fit_rect_calculator_unit.sv]
// Top level: APB registers, front end, queue and back end of the fit calculator.
//
// Takes one texture size per transfer and returns the source crop and the
// destination rectangle for the configured fit mode and bounds. One transfer
// is accepted every cycle while o_ready is high, which output back-pressure can
// pull low. Most of the pipeline is the bit-per-stage divider in the back end;
// the front end classifies the request and feeds a two-entry queue so either
// side can stall alone. Write configuration only while the block is idle.
module image_fit_rect_calculator_unit import ifrc_pkg::*; #(
    parameter int MAX_DIM_BITS = 12,
    parameter int FRAC_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int DW = MAX_DIM_BITS + 1;
    localparam int QW = 2 + 1 + 1 + 4 * DW;

    logic [1:0]  r_fit_mode;
    logic [15:0] r_bounds_x, r_bounds_y;
    logic [12:0] r_bounds_w, r_bounds_h;
    logic [2:0]  reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];

    // Register writes complete on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= MODE_FILL;
            r_bounds_x <= '0;
            r_bounds_y <= '0;
            r_bounds_w <= 13'd1;
            r_bounds_h <= 13'd1;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_FIT_MODE: r_fit_mode <= pwdata[1:0];
                REG_BOUNDS_X: r_bounds_x <= pwdata[15:0];
                REG_BOUNDS_Y: r_bounds_y <= pwdata[15:0];
                REG_BOUNDS_W: r_bounds_w <= pwdata[12:0];
                REG_BOUNDS_H: r_bounds_h <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FIT_MODE: prdata = {30'd0, r_fit_mode};
            REG_BOUNDS_X: prdata = {{16{r_bounds_x[15]}}, r_bounds_x};
            REG_BOUNDS_Y: prdata = {{16{r_bounds_y[15]}}, r_bounds_y};
            REG_BOUNDS_W: prdata = {19'd0, r_bounds_w};
            REG_BOUNDS_H: prdata = {19'd0, r_bounds_h};
            default:      prdata = '0;
        endcase
    end

    // Front end: saturate, cross-multiply, pick the operation.
    logic          f_vld, f_rdy;
    logic [1:0]    f_op;
    logic          f_wider, f_err;
    logic [DW-1:0] f_tw, f_th, f_bw, f_bh;

    ifrc_front #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .i_fit_mode(r_fit_mode), .i_bounds_w(r_bounds_w), .i_bounds_h(r_bounds_h),
        .o_valid(f_vld), .i_ready(f_rdy),
        .o_op(f_op), .o_wider(f_wider), .o_err(f_err),
        .o_tw(f_tw), .o_th(f_th), .o_bw(f_bw), .o_bh(f_bh)
    );

    // Decoupling queue.
    logic          q_vld, q_rdy;
    logic [QW-1:0] q_data;

    ifrc_queue #(.W(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_vld), .o_ready(f_rdy),
        .i_data({f_op, f_wider, f_err, f_tw, f_th, f_bw, f_bh}),
        .o_valid(q_vld), .i_ready(q_rdy), .o_data(q_data)
    );

    // Back end: divider pipeline and output register.
    ifrc_back #(.MAX_DIM_BITS(MAX_DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_vld), .o_ready(q_rdy),
        .i_op(q_data[QW-1 -: 2]), .i_wider(q_data[QW-3]), .i_err(q_data[QW-4]),
        .i_tw(q_data[4*DW-1 -: DW]), .i_th(q_data[3*DW-1 -: DW]),
        .i_bw(q_data[2*DW-1 -: DW]), .i_bh(q_data[DW-1:0]),
        .i_bounds_x(r_bounds_x), .i_bounds_y(r_bounds_y),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // A zero-size error never comes with a cropped source.
    a_err_full_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_size_error |-> o_data.src_x == '0 && o_data.src_y == '0)
        else $error("error result with crop offset");

    // Stalled output holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");
endmodule

[test/tb_image_fit_rect_calculator_unit.sv]
// Testbench for the image fit rectangle calculator: predicts fit rectangles and checks results.
`timescale 1ns / 100ps

module tb_image_fit_rect_calculator_unit;
    import ifrc_pkg::*;

    localparam int DIM_MAX  = 4096;
    localparam int ONE      = 16;
    localparam int LATENCY  = 34;
    localparam int WDOG_MAX = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    image_fit_rect_calculator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [1:0]  cfg_mode = MODE_FILL;
    logic [15:0] cfg_bx = '0;
    logic [15:0] cfg_by = '0;
    logic [12:0] cfg_bw = 13'd1;
    logic [12:0] cfg_bh = 13'd1;

    t_in  pending_sizes[$];
    t_out expected_rects[$];

    int  send_idle_pct = 0;     // sender idle chance, percent
    int  recv_stall_pct = 0;    // receiver stall chance, percent
    int  recv_hold = 0;         // forced long receiver hold-off, cycles
    bit  failed = 1'b0;
    int  quiet_cycles = 0;

    function automatic longint sat_dim(logic [12:0] v);
        return (v > DIM_MAX) ? DIM_MAX : longint'(v);
    endfunction

    // Compute the crop and destination rectangles for one texture size.
    function automatic t_out fit_rect(t_in t);
        t_out r;
        longint tw, th, bw, bh, sx, sy, sw, sh, dx, dy, dw, dh, nw, nh;
        bit wider, contain, err;
        tw = sat_dim(t.tex_width);
        th = sat_dim(t.tex_height);
        bw = sat_dim(cfg_bw);
        bh = sat_dim(cfg_bh);
        sx = 0; sy = 0; sw = tw * ONE; sh = th * ONE;
        dx = longint'($signed(cfg_bx)) * ONE;
        dy = longint'($signed(cfg_by)) * ONE;
        dw = bw * ONE; dh = bh * ONE;
        err = (tw == 0 || th == 0 || bw == 0 || bh == 0);
        if (!err) begin
            wider = (tw * bh) > (th * bw);
            contain = (cfg_mode == MODE_CONTAIN);
            if (cfg_mode == MODE_SCALE) begin
                if (tw <= bw && th <= bh) begin
                    dx += ((bw - tw) * ONE) / 2;
                    dy += ((bh - th) * ONE) / 2;
                    dw = tw * ONE;
                    dh = th * ONE;
                end else begin
                    contain = 1'b1;
                end
            end
            if (contain) begin
                if (wider) begin
                    nh = (bw * th * ONE) / tw;
                    dy += (bh * ONE - nh) / 2;
                    dh = nh;
                end else begin
                    nw = (bh * tw * ONE) / th;
                    dx += (bw * ONE - nw) / 2;
                    dw = nw;
                end
            end else if (cfg_mode == MODE_COVER) begin
                if (wider) begin
                    nw = (th * bw * ONE) / bh;
                    sx = (tw * ONE - nw) / 2;
                    sw = nw;
                end else begin
                    nh = (tw * bh * ONE) / bw;
                    sy = (th * ONE - nh) / 2;
                    sh = nh;
                end
            end
        end
        r.src_x = sx[16:0]; r.src_y = sy[16:0];
        r.src_w = sw[16:0]; r.src_h = sh[16:0];
        r.dst_x = dx[20:0]; r.dst_y = dy[20:0];
        r.dst_w = dw[16:0]; r.dst_h = dh[16:0];
        r.zero_size_error = err;
        return r;
    endfunction

    // Driver: offers the next pending size; predicts on each transfer.
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            expected_rects.push_back(fit_rect(i_data));
            void'(pending_sizes.pop_front());
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_ready) begin
            // hold payload until the transfer completes
        end else if (i_valid && o_ready && pending_sizes.size() != 0
                     && $urandom_range(99) >= send_idle_pct) begin
            i_data <= pending_sizes[0];
        end else if (!i_valid && pending_sizes.size() != 0
                     && $urandom_range(99) >= send_idle_pct) begin
            i_valid <= 1'b1;
            i_data  <= pending_sizes[0];
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_out e;
        if (o_valid && i_ready) begin
            if (expected_rects.size() == 0) begin
                $error("result with no prediction waiting");
                failed = 1'b1;
            end else begin
                e = expected_rects.pop_front();
                if (o_data.src_x !== e.src_x) begin
                    $error("src_x expected %0d got %0d", e.src_x, o_data.src_x); failed = 1'b1;
                end
                if (o_data.src_y !== e.src_y) begin
                    $error("src_y expected %0d got %0d", e.src_y, o_data.src_y); failed = 1'b1;
                end
                if (o_data.src_w !== e.src_w) begin
                    $error("src_w expected %0d got %0d", e.src_w, o_data.src_w); failed = 1'b1;
                end
                if (o_data.src_h !== e.src_h) begin
                    $error("src_h expected %0d got %0d", e.src_h, o_data.src_h); failed = 1'b1;
                end
                if (o_data.dst_x !== e.dst_x) begin
                    $error("dst_x expected %0h got %0h", e.dst_x, o_data.dst_x); failed = 1'b1;
                end
                if (o_data.dst_y !== e.dst_y) begin
                    $error("dst_y expected %0h got %0h", e.dst_y, o_data.dst_y); failed = 1'b1;
                end
                if (o_data.dst_w !== e.dst_w) begin
                    $error("dst_w expected %0d got %0d", e.dst_w, o_data.dst_w); failed = 1'b1;
                end
                if (o_data.dst_h !== e.dst_h) begin
                    $error("dst_h expected %0d got %0d", e.dst_h, o_data.dst_h); failed = 1'b1;
                end
                if (o_data.zero_size_error !== e.zero_size_error) begin
                    $error("zero_size_error expected %0b got %0b",
                           e.zero_size_error, o_data.zero_size_error);
                    failed = 1'b1;
                end
            end
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n
            || recv_hold > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FIT_MODE: cfg_mode = val[1:0];
            REG_BOUNDS_X: cfg_bx = val[15:0];
            REG_BOUNDS_Y: cfg_by = val[15:0];
            REG_BOUNDS_W: cfg_bw = val[12:0];
            REG_BOUNDS_H: cfg_bh = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_sizes.size() != 0 || expected_rects.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic push_size(logic [12:0] w, logic [12:0] h);
        t_in t;
        t.tex_width = w;
        t.tex_height = h;
        pending_sizes.push_back(t);
    endtask

    // Mostly in-range dims, sometimes extremes, zeros and oversize values.
    function automatic logic [12:0] rand_dim();
        case ($urandom_range(9))
            0: return 13'($urandom_range(8191));
            1: return 13'($urandom_range(4097, 4095));
            2: return 13'($urandom_range(2));
            default: return 13'($urandom_range(4096, 1));
        endcase
    endfunction

    task automatic random_config();
        reg_write(REG_FIT_MODE, 32'($urandom_range(3)));
        reg_write(REG_BOUNDS_X, $urandom);
        reg_write(REG_BOUNDS_Y, $urandom);
        reg_write(REG_BOUNDS_W, {19'b0, rand_dim()});
        reg_write(REG_BOUNDS_H, {19'b0, rand_dim()});
    endtask

    initial begin
        int m;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (LATENCY + 4) @(posedge i_clk);

        // Directed: reset bounds, then each mode with extremes and zeros.
        push_size(13'd0, 13'd5);
        push_size(13'd4096, 13'd4096);
        drain();
        reg_write(REG_BOUNDS_X, 32'h0000_8000);
        reg_write(REG_BOUNDS_Y, 32'h0000_7FFF);
        reg_write(REG_BOUNDS_W, 32'd4096);
        reg_write(REG_BOUNDS_H, 32'd2048);
        reg_write(3'd7, 32'hFFFF_FFFF);   // unused index: ignored
        for (m = 0; m < 4; m++) begin
            reg_write(REG_FIT_MODE, 32'(m));
            push_size(13'd1, 13'd1);
            push_size(13'h1FFF, 13'd100);     // oversize width
            push_size(13'd2000, 13'd1000);    // aspect tie
            push_size(13'd0, 13'd0);
            push_size(13'd640, 13'd4096);
            drain();
        end
        reg_write(REG_BOUNDS_W, 32'd0);       // zero bounds width
        push_size(13'd10, 13'd10);
        drain();
        reg_write(REG_BOUNDS_X, 32'h0000_0000);
        reg_write(REG_BOUNDS_Y, 32'hFFFF_FFFF);
        reg_write(REG_BOUNDS_W, 32'h1FFF);    // oversize bounds
        reg_write(REG_BOUNDS_H, 32'd1);
        push_size(13'd4096, 13'd1);
        push_size(13'd1, 13'd4096);
        drain();

        // Random phases under different idling patterns.
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            random_config();
            if (ph == 4) recv_hold = 300;   // receiver holds off, block backs up
            for (int k = 0; k < 100; k++)
                push_size(rand_dim(), rand_dim());
            drain();   // sender pauses until every result is back
        end

        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/ifrc_pkg.sv
rtl/ifrc_front.sv
rtl/ifrc_queue.sv
rtl/ifrc_div.sv
rtl/ifrc_back.sv
rtl/image_fit_rect_calculator_unit.sv
test/tb_image_fit_rect_calculator_unit.sv
